@@ src/i2cseq_pkg.sv @@
package i2cseq_pkg;

	// Default transfer buffer depth
	localparam int BUF_DEPTH_DEF = 32;

	// Command codes
	typedef enum logic [2:0] {
		OP_LOAD      = 3'd0,
		OP_START_WR  = 3'd1,
		OP_START_CMB = 3'd2,
		OP_STATUS    = 3'd3,
		OP_READ      = 3'd4
	} op_t;

	// Bus actions
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_PUT     = 3'd2,
		ACT_RESTART = 3'd3,
		ACT_STOP    = 3'd4
	} action_t;

	// Acknowledge control
	typedef enum logic [1:0] {
		ACK_KEEP = 2'd0,
		ACK_SET  = 2'd1,
		ACK_CLR  = 2'd2
	} ack_t;

	// Bus status codes
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_RESTART   = 8'h10;
	localparam logic [7:0] ST_ADDR_W    = 8'h18;
	localparam logic [7:0] ST_DATA_SENT = 8'h28;
	localparam logic [7:0] ST_ADDR_R    = 8'h40;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;
	localparam logic [7:0] READ_BIT     = 8'h01;

	// Command word
	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] device_address;
		logic [7:0] sub_address;
		logic [5:0] length;
		logic [7:0] status_code;
		logic [7:0] bus_byte;
		logic [4:0] buffer_index;
	} cmd_word_t;

	// Response word
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] out_byte;
		logic [1:0] ack_control;
		logic       clear_start;
		logic       transfer_done;
		logic [5:0] bytes_left;
	} rsp_word_t;

endpackage

@@ src/i2c_master_transfer_sequencer.sv @@
// I2C master transfer sequencer.
// Command channel (cmd_valid / cmd_stall / cmd): loads buffer bytes, starts a
// write or a combined/read transfer, reports bus status events, or reads back
// a buffer byte. Response channel (rsp_valid / rsp_stall / rsp): one word per
// command with the next bus action, byte to send, ack control and done flag.
// A command is taken on an edge with cmd_valid high and cmd_stall low.
// The edge that takes the command loads the decision/buffer-read register;
// a later edge, once the output register is free, loads the output register
// and raises rsp_valid. Throughput: one command per cycle while the receiver
// does not stall; the decision and a single read port on the transfer buffer
// both keep up with that rate.
// Receiver stall: the output register holds its word; the decision register
// keeps accepting until it too is full, then cmd_stall rises.
// Reset clears the transfer state and both valid flags; buffer contents are
// undefined until loaded or received.
module i2c_master_transfer_sequencer
	import i2cseq_pkg::*;
#(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int PW = $clog2(BUF_DEPTH + 1);
	localparam logic [5:0] LEN_MAX = (BUF_DEPTH > 63) ? 6'd63 : 6'(BUF_DEPTH);

	// transfer state
	logic [7:0]    target_q;
	logic [7:0]    subaddr_q;
	logic          restart_q;
	logic [5:0]    remain_q;
	logic [PW-1:0] pos_q;

	logic [7:0]    target_d;
	logic [7:0]    subaddr_d;
	logic          restart_d;
	logic [5:0]    remain_d;
	logic [PW-1:0] pos_d;

	// transfer buffer
	logic [7:0]    buf_mem [BUF_DEPTH];
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	// decision stage
	logic          valid_s1;
	logic [2:0]    action_s1;
	logic [7:0]    byte_s1;
	logic          use_mem_s1;
	logic [7:0]    rd_s1;
	logic [1:0]    ack_s1;
	logic          clr_s1;
	logic          done_s1;
	logic [5:0]    left_s1;

	logic          rsp_valid_q;
	rsp_word_t     rsp_q;

	action_t       act;
	ack_t          ack;
	logic [7:0]    byte_val;
	logic          use_mem;
	logic          clr;
	logic          done;
	logic          accept;
	logic          out_free;
	logic          have_room;
	logic          idx_ok;
	logic [5:0]    len_clamped;

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !out_free;
	assign accept    = cmd_valid && !cmd_stall;

	assign idx_ok      = 32'(cmd.buffer_index) < BUF_DEPTH;
	assign have_room   = (remain_q != 6'd0) && (32'(pos_q) < BUF_DEPTH);
	assign len_clamped = (cmd.length > LEN_MAX) ? LEN_MAX : cmd.length;

	// command decode and next transfer state
	always_comb begin
		target_d  = target_q;
		subaddr_d = subaddr_q;
		restart_d = restart_q;
		remain_d  = remain_q;
		pos_d     = pos_q;
		act       = ACT_NONE;
		ack       = ACK_KEEP;
		clr       = 1'b0;
		done      = 1'b0;
		byte_val  = 8'd0;
		use_mem   = 1'b0;
		we        = 1'b0;
		waddr     = AW'(pos_q);
		raddr     = AW'(pos_q);
		case (cmd.operation)
			OP_LOAD: begin
				we    = idx_ok;
				waddr = AW'(cmd.buffer_index);
			end
			OP_START_WR: begin
				restart_d = 1'b0;
				subaddr_d = 8'd0;
				target_d  = cmd.device_address & ~READ_BIT;
				pos_d     = '0;
				remain_d  = len_clamped;
				act       = ACT_START;
			end
			OP_START_CMB: begin
				restart_d = 1'b0;
				subaddr_d = cmd.sub_address;
				target_d  = (cmd.sub_address != 8'd0) ? (cmd.device_address & ~READ_BIT)
					: (cmd.device_address | READ_BIT);
				pos_d     = '0;
				remain_d  = len_clamped;
				act       = ACT_START;
			end
			OP_STATUS: begin
				if (cmd.status_code == ST_START) begin
					act      = ACT_PUT;
					byte_val = target_q;
					clr      = 1'b1;
				end else if (cmd.status_code == ST_RESTART) begin
					act      = ACT_PUT;
					byte_val = target_q | READ_BIT;
					clr      = 1'b1;
				end else if (cmd.status_code == ST_ADDR_W || cmd.status_code == ST_DATA_SENT) begin
					if (restart_q) begin
						act = ACT_RESTART;
					end else if (subaddr_q != 8'd0) begin
						act       = ACT_PUT;
						byte_val  = subaddr_q;
						subaddr_d = 8'd0;
						restart_d = 1'b1;
					end else if (have_room) begin
						act      = ACT_PUT;
						use_mem  = 1'b1;
						pos_d    = pos_q + PW'(1);
						remain_d = remain_q - 6'd1;
					end else begin
						act  = ACT_STOP;
						done = 1'b1;
					end
				end else if (cmd.status_code == ST_ADDR_R) begin
					ack = ACK_SET;
				end else if (cmd.status_code == ST_RX_ACK || cmd.status_code == ST_RX_NACK) begin
					if (have_room) begin
						we       = 1'b1;
						pos_d    = pos_q + PW'(1);
						remain_d = remain_q - 6'd1;
						ack      = (remain_q != 6'd1) ? ACK_SET : ACK_CLR;
					end else begin
						act  = ACT_STOP;
						done = 1'b1;
					end
				end
			end
			OP_READ: begin
				use_mem = idx_ok;
				raddr   = AW'(cmd.buffer_index);
			end
			default: begin
			end
		endcase
	end

	// transfer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 8'd0;
			subaddr_q <= 8'd0;
			restart_q <= 1'b0;
			remain_q  <= 6'd0;
			pos_q     <= '0;
		end else if (accept) begin
			target_q  <= target_d;
			subaddr_q <= subaddr_d;
			restart_q <= restart_d;
			remain_q  <= remain_d;
			pos_q     <= pos_d;
		end
	end

	// buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && we) begin
			buf_mem[waddr] <= cmd.bus_byte;
		end
		if (accept) begin
			rd_s1 <= buf_mem[raddr];
		end
	end

	// decision stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// decision stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= act;
			byte_s1    <= byte_val;
			use_mem_s1 <= use_mem;
			ack_s1     <= ack;
			clr_s1     <= clr;
			done_s1    <= done;
			left_s1    <= remain_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q.action        <= action_s1;
			rsp_q.out_byte      <= use_mem_s1 ? rd_s1 : byte_s1;
			rsp_q.ack_control   <= ack_s1;
			rsp_q.clear_start   <= clr_s1;
			rsp_q.transfer_done <= done_s1;
			rsp_q.bytes_left    <= left_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
